[hw/rtl/bcpu_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcpu_pkg
// Shared types and constants for the byte CPU execute step: beat structs,
// opcodes, error codes, view selectors and ALU modes.
// ----------------------------------------------------------------------------
package bcpu_pkg;

  localparam int NUM_REGS  = 8;
  localparam int REG_W     = 8;
  localparam int RAM_DEPTH = 256;
  localparam int RAM_AW    = 8;
  localparam int PW_W      = 9;

  localparam logic [PW_W-1:0] PROG_WORDS_RESET = 9'd256;

  // register roles
  localparam logic [2:0] REG_IDX0     = 3'd0;
  localparam logic [2:0] REG_IDX1     = 3'd1;
  localparam logic [2:0] REG_SRC      = 3'd2;
  localparam logic [2:0] REG_FP       = 3'd3;
  localparam logic [2:0] REG_ALU_X    = 3'd4;
  localparam logic [2:0] REG_ALU_Y    = 3'd5;
  localparam logic [2:0] REG_ALU_MODE = 3'd6;
  localparam logic [2:0] REG_MONITOR  = 3'd7;

  // opcodes
  localparam logic [7:0] OP_HALT      = 8'd0;
  localparam logic [7:0] OP_LD        = 8'd1;
  localparam logic [7:0] OP_ST_VIEW   = 8'd2;
  localparam logic [7:0] OP_LI        = 8'd3;
  localparam logic [7:0] OP_STI       = 8'd4;
  localparam logic [7:0] OP_MOV_VIEW  = 8'd5;
  localparam logic [7:0] OP_JMP       = 8'd6;
  localparam logic [7:0] OP_JNZ       = 8'd7;
  localparam logic [7:0] OP_JR        = 8'd8;
  localparam logic [7:0] OP_LD_IDX    = 8'd9;
  localparam logic [7:0] OP_ST_IDX_VW = 8'd10;
  localparam logic [7:0] OP_ST_IDX_R2 = 8'd11;

  // error codes
  localparam logic [2:0] ERR_NONE   = 3'd0;
  localparam logic [2:0] ERR_OPCODE = 3'd1;
  localparam logic [2:0] ERR_WRITE  = 3'd2;
  localparam logic [2:0] ERR_READ   = 3'd3;
  localparam logic [2:0] ERR_ALU    = 3'd4;
  localparam logic [2:0] ERR_PTR    = 3'd5;

  // read views
  localparam logic [7:0] VIEW_FP  = 8'd0;
  localparam logic [7:0] VIEW_IDX = 8'd1;
  localparam logic [7:0] VIEW_ALU = 8'd2;

  // ALU modes
  localparam logic [7:0] ALU_ADD = 8'd0;
  localparam logic [7:0] ALU_GT  = 8'd1;
  localparam logic [7:0] ALU_EQ  = 8'd2;
  localparam logic [7:0] ALU_LT  = 8'd3;

  typedef struct packed {
    logic [7:0] kind;
    logic [7:0] operand_a;
    logic [7:0] operand_b;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] next_pointer;
    logic       stopped;
    logic [2:0] error_code;
    logic       monitor_valid;
    logic [7:0] monitor_value;
  } out_beat_t;

  typedef logic [NUM_REGS-1:0][REG_W-1:0] reg_file_t;

  typedef struct packed {
    logic              reg_we;
    logic [2:0]        reg_sel;
    logic [REG_W-1:0]  reg_val;
    logic              ram_we;
    logic [RAM_AW-1:0] ram_addr;
    logic [REG_W-1:0]  ram_val;
    logic              ip_we;
    logic [7:0]        ip_nxt;
    logic              stop_set;
    logic [2:0]        err;
    logic              monitor_valid;
  } exec_upd_t;

endpackage

[hw/rtl/bcpu_dmem.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcpu_dmem
// 256 x 8 data RAM, one read and one write port, registered read data.
// Sweeps every entry to zero after reset, one entry per cycle.
// ----------------------------------------------------------------------------
module bcpu_dmem (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [bcpu_pkg::RAM_AW-1:0] rd_addr,
  output logic [bcpu_pkg::REG_W-1:0]  rd_data,
  input  logic                       wr_en,
  input  logic [bcpu_pkg::RAM_AW-1:0] wr_addr,
  input  logic [bcpu_pkg::REG_W-1:0]  wr_data,
  output logic                       clearing
);
  import bcpu_pkg::*;

  logic [REG_W-1:0]  mem [RAM_DEPTH];
  logic [RAM_AW:0]   clr_cnt_r;
  logic [RAM_AW:0]   clr_cnt_nxt;
  logic [REG_W-1:0]  rd_data_r;
  logic              we;
  logic [RAM_AW-1:0] waddr;
  logic [REG_W-1:0]  wdata;

  assign clearing    = !clr_cnt_r[RAM_AW];
  assign clr_cnt_nxt = clr_cnt_r + {{RAM_AW{1'b0}}, 1'b1};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (clearing) begin
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  always_comb begin
    we    = clearing ? 1'b1 : wr_en;
    waddr = clearing ? clr_cnt_r[RAM_AW-1:0] : wr_addr;
    wdata = clearing ? '0 : wr_data;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

[hw/rtl/bcpu_exec.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcpu_exec
// Execute logic: decodes one instruction, evaluates read views and the ALU,
// and forms the register, RAM, pointer and stop updates.
// ----------------------------------------------------------------------------
module bcpu_exec (
  input  bcpu_pkg::in_beat_t          item,
  input  logic [bcpu_pkg::REG_W-1:0]  ram_rdata,
  input  bcpu_pkg::reg_file_t         regs,
  input  logic [7:0]                  ip,
  input  logic                        stopped,
  input  logic [bcpu_pkg::PW_W-1:0]   prog_words,
  output bcpu_pkg::exec_upd_t         upd
);
  import bcpu_pkg::*;

  logic [7:0]       vsel;
  logic [REG_W-1:0] vval;
  logic [2:0]       verr;
  logic [7:0]       wsel;
  logic [REG_W-1:0] wval;
  logic             do_w;
  logic             halt;
  logic [2:0]       err;
  logic [7:0]       idx;
  logic [REG_W-1:0] alu_x;
  logic [REG_W-1:0] alu_y;

  assign idx   = regs[REG_IDX0] + regs[REG_IDX1];
  assign alu_x = regs[REG_ALU_X];
  assign alu_y = regs[REG_ALU_Y];
  assign vsel  = (item.kind == OP_ST_VIEW) ? item.operand_b : item.operand_a;
  assign wsel  = (item.kind == OP_LD_IDX) ? item.operand_a : item.operand_b;

  always_comb begin
    vval = '0;
    verr = ERR_NONE;
    unique case (vsel)
      VIEW_FP:  vval = regs[REG_FP];
      VIEW_IDX: vval = idx;
      VIEW_ALU: begin
        unique case (regs[REG_ALU_MODE])
          ALU_ADD: vval = alu_x + alu_y;
          ALU_GT:  vval = {7'd0, alu_x > alu_y};
          ALU_EQ:  vval = {7'd0, alu_x == alu_y};
          ALU_LT:  vval = {7'd0, alu_x < alu_y};
          default: verr = ERR_ALU;
        endcase
      end
      default: verr = ERR_READ;
    endcase
  end

  always_comb begin
    upd          = '0;
    upd.ip_nxt   = ip + 8'd1;
    upd.reg_sel  = wsel[2:0];
    err          = ERR_NONE;
    halt         = 1'b0;
    do_w         = 1'b0;
    wval         = '0;
    if (!stopped) begin
      if ({1'b0, ip} >= prog_words) begin
        err = ERR_PTR;
      end else begin
        unique case (item.kind)
          OP_HALT: halt = 1'b1;
          OP_LD: begin
            do_w = 1'b1;
            wval = ram_rdata;
          end
          OP_ST_VIEW: begin
            if (verr != ERR_NONE) begin
              err = verr;
            end else begin
              upd.ram_we   = 1'b1;
              upd.ram_addr = item.operand_a;
              upd.ram_val  = vval;
            end
          end
          OP_LI: begin
            do_w = 1'b1;
            wval = item.operand_a;
          end
          OP_STI: begin
            upd.ram_we   = 1'b1;
            upd.ram_addr = item.operand_a;
            upd.ram_val  = item.operand_b;
          end
          OP_MOV_VIEW: begin
            if (verr != ERR_NONE) begin
              err = verr;
            end else begin
              do_w = 1'b1;
              wval = vval;
            end
          end
          OP_JMP: upd.ip_nxt = item.operand_a;
          OP_JNZ: begin
            if (regs[REG_IDX0] != '0) begin
              upd.ip_nxt = item.operand_a;
            end
          end
          OP_JR: upd.ip_nxt = regs[REG_IDX0];
          OP_LD_IDX: begin
            do_w = 1'b1;
            wval = ram_rdata;
          end
          OP_ST_IDX_VW: begin
            if (verr != ERR_NONE) begin
              err = verr;
            end else begin
              upd.ram_we   = 1'b1;
              upd.ram_addr = idx;
              upd.ram_val  = vval;
            end
          end
          OP_ST_IDX_R2: begin
            upd.ram_we   = 1'b1;
            upd.ram_addr = idx;
            upd.ram_val  = regs[REG_SRC];
          end
          default: err = ERR_OPCODE;
        endcase
        if (do_w) begin
          if (wsel[7:3] != '0) begin
            err = ERR_WRITE;
          end else begin
            upd.reg_we  = 1'b1;
            upd.reg_val = wval;
          end
        end
      end
      upd.err      = err;
      upd.stop_set = halt || (err != ERR_NONE);
      upd.ip_we    = !upd.stop_set;
      if (upd.stop_set) begin
        upd.reg_we = 1'b0;
        upd.ram_we = 1'b0;
      end
      upd.monitor_valid = upd.reg_we && (upd.reg_sel == REG_MONITOR);
    end
  end

endmodule

[hw/rtl/byte_cpu_execute_step.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_cpu_execute_step
// Executes one fetched instruction of a tiny 8-bit machine per input beat
// and returns the next pointer, stop/error status and monitor writes.
// ----------------------------------------------------------------------------
// Flow: the beat is registered with its data RAM read, then executed into the
//   result register. One instruction is in flight between the data RAM read
//   and execute/write-back; in_ready stays low until it has executed.
// Reset: registers, pointer and stop state clear at once; the data RAM is
//   swept to zero one entry at a time, with in_ready low during the sweep.
// ----------------------------------------------------------------------------
module byte_cpu_execute_step (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  bcpu_pkg::in_beat_t          in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output bcpu_pkg::out_beat_t         out_data,
  input  logic                        cfg_we,
  input  logic [bcpu_pkg::PW_W-1:0]   cfg_wdata
);
  import bcpu_pkg::*;

  logic              clearing;
  logic              in_fire;
  logic              exec_fire;
  logic              s1_valid_r;
  in_beat_t          s1_item_r;
  logic [RAM_AW-1:0] s1_addr_r;
  logic [RAM_AW-1:0] acc_addr;
  logic [RAM_AW-1:0] rd_addr;
  logic [REG_W-1:0]  rd_data;
  reg_file_t         reg_file_r;
  logic [7:0]        ip_r;
  logic [7:0]        ip_nxt;
  logic              stop_r;
  logic              stop_nxt;
  logic [2:0]        err_r;
  logic [2:0]        err_nxt;
  logic [PW_W-1:0]   pw_r;
  logic              out_valid_r;
  out_beat_t         out_r;
  out_beat_t         out_nxt;
  exec_upd_t         upd;

  assign in_ready  = !clearing && !s1_valid_r;
  assign in_fire   = in_valid && in_ready;
  assign exec_fire = s1_valid_r && (!out_valid_r || out_ready);

  assign acc_addr = (in_data.kind == OP_LD_IDX) ?
                    (reg_file_r[REG_IDX0] + reg_file_r[REG_IDX1]) : in_data.operand_a;
  assign rd_addr  = s1_valid_r ? s1_addr_r : acc_addr;

  bcpu_dmem u_dmem (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .wr_en    (exec_fire && upd.ram_we),
    .wr_addr  (upd.ram_addr),
    .wr_data  (upd.ram_val),
    .clearing (clearing)
  );

  bcpu_exec u_exec (
    .item       (s1_item_r),
    .ram_rdata  (rd_data),
    .regs       (reg_file_r),
    .ip         (ip_r),
    .stopped    (stop_r),
    .prog_words (pw_r),
    .upd        (upd)
  );

  always_comb begin
    ip_nxt   = upd.ip_we ? upd.ip_nxt : ip_r;
    stop_nxt = stop_r || upd.stop_set;
    err_nxt  = upd.stop_set ? upd.err : err_r;
    out_nxt.next_pointer  = ip_nxt;
    out_nxt.stopped       = stop_nxt;
    out_nxt.error_code    = err_nxt;
    out_nxt.monitor_valid = upd.monitor_valid;
    out_nxt.monitor_value = upd.monitor_valid ? upd.reg_val : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pw_r <= PROG_WORDS_RESET;
    end else if (cfg_we) begin
      pw_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (exec_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r <= in_data;
      s1_addr_r <= acc_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reg_file_r <= '0;
      ip_r       <= '0;
      stop_r     <= 1'b0;
      err_r      <= ERR_NONE;
    end else if (exec_fire) begin
      if (upd.reg_we) begin
        reg_file_r[upd.reg_sel] <= upd.reg_val;
      end
      ip_r   <= ip_nxt;
      stop_r <= stop_nxt;
      err_r  <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (exec_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_stop_holds: assert property (@(posedge clk) disable iff (!rst_n)
    stop_r |=> stop_r && $stable(ip_r) && $stable(err_r))
    else $error("stopped state changed");

  a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> s1_valid_r && !in_ready)
    else $error("accepted beat not held for execute");

  a_monitor_not_stopped: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.monitor_valid |-> !out_r.stopped)
    else $error("monitor write reported with stop");

  a_no_accept_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !s1_valid_r && !out_valid_r)
    else $error("work in flight during RAM clear");
`endif

endmodule
